// ===== design/srdm_pkg.sv =====
package srdm_pkg;

   // descriptor count and the widths that follow from it
   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int ENC_W = IDX_W + 1;
   localparam int SIZE_W = IDX_W + 1;

   // fixed field widths
   localparam int KIND_W = 2;
   localparam int BUF_ADDR_W = 64;
   localparam int LEN_W = 32;
   localparam int ID_W = 32;
   localparam int STATUS_W = 4;
   localparam int CNT_W = 16;
   localparam int TICK_W = 16;

   // register port
   localparam int APB_ADDR_W = 3;
   localparam int APB_DATA_W = 32;
   localparam logic REG_QSIZE = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(QUEUE_DEPTH);
   localparam logic [TICK_W-1:0] RESET_TIMEOUT = TICK_W'(200);

   // next pointer as stored: index bits plus an end-of-list bit
   localparam logic [ENC_W-1:0] END_CODE = '1;

   // remainder unit: bits retired per cycle
   localparam int MOD_BITS = 4;
   localparam int MOD_STEPS = CNT_W / MOD_BITS;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);

   typedef enum logic [KIND_W-1:0] {
      KIND_INIT     = 2'd0,
      KIND_SUBMIT   = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_TICK     = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_INIT_DONE     = 4'd0,
      RS_SUBMITTED     = 4'd1,
      RS_COMPLETED     = 4'd2,
      RS_NO_FREE       = 4'd3,
      RS_LIST_CORRUPT  = 4'd4,
      RS_WRONG_ID      = 4'd5,
      RS_TIMEOUT       = 4'd6,
      RS_BROKEN        = 4'd7,
      RS_REFUSED       = 4'd8
   } status_type;

   typedef struct packed {
      logic accept;
      logic rd_en;
      logic rd_next;
      logic cap_d1;
      logic mod_start;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic mod_busy;
   } sts_type;

   // queue size register to descriptor count
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] q);
      logic [SIZE_W-1:0] n;
      n = q;
      if (q == '0) begin
         n = SIZE_W'(QUEUE_DEPTH);
      end else if (q < SIZE_W'(2)) begin
         n = SIZE_W'(2);
      end else if (q > SIZE_W'(QUEUE_DEPTH)) begin
         n = SIZE_W'(QUEUE_DEPTH);
      end
      return n;
   endfunction

   // next pointer of a descriptor not written since the free list was built
   function automatic logic [ENC_W-1:0] rst_next(input logic [IDX_W-1:0] i,
                                                 input logic [SIZE_W-1:0] n0);
      logic [ENC_W-1:0] succ;
      logic [ENC_W-1:0] res;
      succ = ENC_W'(i) + ENC_W'(1);
      if (succ < n0) begin
         res = succ;
      end else if (succ == n0) begin
         res = END_CODE;
      end else begin
         res = '0;
      end
      return res;
   endfunction

endpackage

// ===== design/srdm_if.sv =====
interface srdm_req_if;
   logic                                valid;
   logic                                ready;
   logic [srdm_pkg::KIND_W-1:0]         kind;
   logic [srdm_pkg::BUF_ADDR_W-1:0]     cmd_buf_addr;
   logic [srdm_pkg::LEN_W-1:0]          cmd_len;
   logic [srdm_pkg::BUF_ADDR_W-1:0]     resp_addr;
   logic [srdm_pkg::LEN_W-1:0]          resp_buf_len;
   logic [srdm_pkg::ID_W-1:0]           used_id;

   modport source (output valid, kind, cmd_buf_addr, cmd_len, resp_addr, resp_buf_len,
                   used_id, input ready);
   modport sink (input valid, kind, cmd_buf_addr, cmd_len, resp_addr, resp_buf_len,
                 used_id, output ready);
endinterface

interface srdm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [srdm_pkg::STATUS_W-1:0]       status;
   logic [srdm_pkg::IDX_W-1:0]          head_index;
   logic [srdm_pkg::IDX_W-1:0]          second_index;
   logic [srdm_pkg::IDX_W-1:0]          avail_slot;
   logic [srdm_pkg::CNT_W-1:0]          avail_count;
   logic [srdm_pkg::IDX_W-1:0]          used_ring_slot;

   modport source (output valid, status, head_index, second_index, avail_slot, avail_count,
                   used_ring_slot, input ready);
   modport sink (input valid, status, head_index, second_index, avail_slot, avail_count,
                 used_ring_slot, output ready);
endinterface

// ===== design/srdm_mod.sv =====
module srdm_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [srdm_pkg::CNT_W-1:0]    dividend,
   input  logic [srdm_pkg::SIZE_W-1:0]   divisor,
   output logic                          busy,
   output logic [srdm_pkg::IDX_W-1:0]    remainder
);

   logic                              busy_ff, busy_in;
   logic [srdm_pkg::MOD_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [srdm_pkg::CNT_W-1:0]        quo_ff, quo_in;
   logic [srdm_pkg::IDX_W-1:0]        rem_ff, rem_in;
   logic [srdm_pkg::SIZE_W-1:0]       div_ff, div_in;

   // restoring remainder, a few bits per cycle
   always_comb begin
      logic [srdm_pkg::SIZE_W-1:0] r;
      r = srdm_pkg::SIZE_W'(rem_ff);
      for (int k = 0; k < srdm_pkg::MOD_BITS; k++) begin
         r = {r[srdm_pkg::IDX_W-1:0], quo_ff[srdm_pkg::CNT_W-1-k]};
         if (r >= div_ff) begin
            r = r - div_ff;
         end
      end
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         quo_in = quo_ff << srdm_pkg::MOD_BITS;
         rem_in = r[srdm_pkg::IDX_W-1:0];
         cnt_in = cnt_ff + srdm_pkg::MOD_CNT_W'(1);
         if (cnt_ff == srdm_pkg::MOD_CNT_W'(srdm_pkg::MOD_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy = busy_ff;
   assign remainder = rem_ff;

`ifndef ASSERT_OFF
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> (srdm_pkg::SIZE_W'(rem_ff) < div_ff))
      else $error("remainder not below divisor");
`endif

endmodule

// ===== design/srdm_ctl.sv =====
module srdm_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_init,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output srdm_pkg::cmd_type    cmd,
   input  srdm_pkg::sts_type    sts
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_READ_HEAD = 5'b00010,
      ST_READ_NEXT = 5'b00100,
      ST_WAIT_MOD  = 5'b01000,
      ST_EXEC      = 5'b10000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = req_init ? ST_EXEC : ST_READ_HEAD;
            end
         end
         ST_READ_HEAD: begin
            cmd.rd_en = 1'b1;
            cmd.mod_start = 1'b1;
            state_in = ST_READ_NEXT;
         end
         ST_READ_NEXT: begin
            cmd.rd_en = 1'b1;
            cmd.rd_next = 1'b1;
            cmd.cap_d1 = 1'b1;
            state_in = ST_WAIT_MOD;
         end
         ST_WAIT_MOD: begin
            if (!sts.mod_busy) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_hold_for_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT_MOD && sts.mod_busy) |=> (state_ff == ST_WAIT_MOD))
      else $error("left remainder wait early");
   a_exec_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid_ff)
      else $error("result not presented after execute");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while stalled");
`endif

endmodule

// ===== design/srdm_dp.sv =====
module srdm_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  srdm_pkg::cmd_type               cmd,
   output srdm_pkg::sts_type               sts,
   input  logic [srdm_pkg::SIZE_W-1:0]     qsize,
   input  logic [srdm_pkg::TICK_W-1:0]     timeout_ticks,
   input  logic [srdm_pkg::KIND_W-1:0]     req_kind,
   input  logic [srdm_pkg::ID_W-1:0]       req_used_id,
   output logic [srdm_pkg::STATUS_W-1:0]   rsp_status,
   output logic [srdm_pkg::IDX_W-1:0]      rsp_head_index,
   output logic [srdm_pkg::IDX_W-1:0]      rsp_second_index,
   output logic [srdm_pkg::IDX_W-1:0]      rsp_avail_slot,
   output logic [srdm_pkg::CNT_W-1:0]      rsp_avail_count,
   output logic [srdm_pkg::IDX_W-1:0]      rsp_used_ring_slot
);

   localparam int DEPTH = srdm_pkg::QUEUE_DEPTH;
   localparam int IW = srdm_pkg::IDX_W;
   localparam int EW = srdm_pkg::ENC_W;
   localparam int CW = srdm_pkg::CNT_W;

   // latched item
   srdm_pkg::kind_type           kind_ff;
   logic [srdm_pkg::ID_W-1:0]    used_id_ff;

   // next-pointer memory with per-entry valid bits
   logic [EW-1:0]                next_mem_ff [DEPTH];
   logic [DEPTH-1:0]             valid_ff, valid_in;
   logic [EW-1:0]                mem_q_ff;
   logic [IW-1:0]                rd_addr_ff;
   logic                         rd_valid_ff;
   logic [EW-1:0]                rd_word;
   logic [IW-1:0]                rd_addr;
   logic                         wr_en;
   logic [IW-1:0]                wr_addr;
   logic [EW-1:0]                wr_data;

   // ring state
   logic [EW-1:0]                d1_ff;
   logic [CW-1:0]                avail_ff, avail_in;
   logic [CW-1:0]                used_ff, used_in;
   logic [EW-1:0]                free_first_ff, free_first_in;
   logic                         broken_ff, broken_in;
   logic                         pending_ff, pending_in;
   logic [IW-1:0]                phead_ff, phead_in;
   logic [srdm_pkg::TICK_W-1:0]  elapsed_ff, elapsed_in, elapsed_inc;
   logic [srdm_pkg::SIZE_W-1:0]  n0_ff, n0_in;
   logic [srdm_pkg::SIZE_W-1:0]  eff_n;

   // result register
   srdm_pkg::status_type         status_in, status_ff;
   logic [IW-1:0]                head_in, head_ff;
   logic [IW-1:0]                second_in, second_ff;
   logic [IW-1:0]                aslot_in, aslot_ff;
   logic [IW-1:0]                uslot_in, uslot_ff;
   logic [CW-1:0]                acount_ff;

   logic                         mod_busy;
   logic [IW-1:0]                mod_rem;
   logic [CW-1:0]                mod_dividend;
   logic                         id_match;

   assign eff_n = srdm_pkg::eff_size(qsize);

   srdm_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_dividend),
      .divisor   (eff_n),
      .busy      (mod_busy),
      .remainder (mod_rem)
   );

   assign mod_dividend = (kind_ff == srdm_pkg::KIND_SUBMIT) ? avail_ff : used_ff;
   assign sts.mod_busy = mod_busy;

   // unwritten entries read as the list built at the last init or at reset
   assign rd_word = rd_valid_ff ? mem_q_ff : srdm_pkg::rst_next(rd_addr_ff, n0_ff);
   assign rd_addr = cmd.rd_next ? rd_word[IW-1:0] :
                    (kind_ff == srdm_pkg::KIND_SUBMIT) ? free_first_ff[IW-1:0] : phead_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         mem_q_ff <= next_mem_ff[rd_addr];
         rd_addr_ff <= rd_addr;
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.exec && wr_en) begin
         next_mem_ff[wr_addr] <= wr_data;
      end
   end

   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff :
                        elapsed_ff + srdm_pkg::TICK_W'(1);
   assign id_match = (used_id_ff == srdm_pkg::ID_W'(phead_ff));

   always_comb begin
      valid_in = valid_ff;
      avail_in = avail_ff;
      used_in = used_ff;
      free_first_in = free_first_ff;
      broken_in = broken_ff;
      pending_in = pending_ff;
      phead_in = phead_ff;
      elapsed_in = elapsed_ff;
      n0_in = n0_ff;
      wr_en = 1'b0;
      wr_addr = d1_ff[IW-1:0];
      wr_data = '0;
      status_in = srdm_pkg::RS_REFUSED;
      head_in = '0;
      second_in = '0;
      aslot_in = '0;
      uslot_in = '0;
      unique case (kind_ff)
         srdm_pkg::KIND_INIT: begin
            valid_in = '0;
            n0_in = eff_n;
            avail_in = '0;
            used_in = '0;
            free_first_in = '0;
            broken_in = 1'b0;
            pending_in = 1'b0;
            phead_in = '0;
            elapsed_in = '0;
            status_in = srdm_pkg::RS_INIT_DONE;
         end
         srdm_pkg::KIND_SUBMIT: begin
            priority if (pending_ff) begin
               status_in = srdm_pkg::RS_REFUSED;
            end else if (broken_ff) begin
               status_in = srdm_pkg::RS_BROKEN;
            end else if (free_first_ff >= eff_n) begin
               status_in = srdm_pkg::RS_NO_FREE;
            end else if (d1_ff >= eff_n || d1_ff == free_first_ff) begin
               broken_in = 1'b1;
               status_in = srdm_pkg::RS_LIST_CORRUPT;
            end else begin
               // response descriptor's next pointer is written as zero
               wr_en = 1'b1;
               wr_addr = d1_ff[IW-1:0];
               wr_data = '0;
               free_first_in = rd_word;
               aslot_in = mod_rem;
               avail_in = avail_ff + CW'(1);
               pending_in = 1'b1;
               phead_in = free_first_ff[IW-1:0];
               elapsed_in = '0;
               head_in = free_first_ff[IW-1:0];
               second_in = d1_ff[IW-1:0];
               status_in = srdm_pkg::RS_SUBMITTED;
            end
         end
         srdm_pkg::KIND_COMPLETE: begin
            if (pending_ff) begin
               uslot_in = mod_rem;
               used_in = used_ff + CW'(1);
               pending_in = 1'b0;
               head_in = phead_ff;
               if (!id_match || d1_ff[IW]) begin
                  broken_in = 1'b1;
                  status_in = srdm_pkg::RS_WRONG_ID;
               end else begin
                  // chain goes back on the front of the free list
                  wr_en = 1'b1;
                  wr_addr = d1_ff[IW-1:0];
                  wr_data = free_first_ff;
                  free_first_in = EW'(phead_ff);
                  second_in = d1_ff[IW-1:0];
                  status_in = srdm_pkg::RS_COMPLETED;
               end
            end
         end
         srdm_pkg::KIND_TICK: begin
            if (pending_ff) begin
               elapsed_in = elapsed_inc;
               head_in = phead_ff;
               second_in = d1_ff[IW-1:0];
               if (elapsed_inc >= timeout_ticks) begin
                  broken_in = 1'b1;
                  pending_in = 1'b0;
                  status_in = srdm_pkg::RS_TIMEOUT;
               end else begin
                  status_in = srdm_pkg::RS_SUBMITTED;
               end
            end
         end
         default: begin
            status_in = srdm_pkg::RS_REFUSED;
         end
      endcase
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         avail_ff <= '0;
         used_ff <= '0;
         free_first_ff <= '0;
         broken_ff <= 1'b0;
         pending_ff <= 1'b0;
         phead_ff <= '0;
         elapsed_ff <= '0;
         n0_ff <= srdm_pkg::RESET_SIZE;
      end else if (cmd.exec) begin
         valid_ff <= valid_in;
         avail_ff <= avail_in;
         used_ff <= used_in;
         free_first_ff <= free_first_in;
         broken_ff <= broken_in;
         pending_ff <= pending_in;
         phead_ff <= phead_in;
         elapsed_ff <= elapsed_in;
         n0_ff <= n0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= srdm_pkg::kind_type'(req_kind);
         used_id_ff <= req_used_id;
      end
      if (cmd.cap_d1) begin
         d1_ff <= rd_word;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         head_ff <= head_in;
         second_ff <= second_in;
         aslot_ff <= aslot_in;
         uslot_ff <= uslot_in;
         acount_ff <= avail_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_head_index = head_ff;
   assign rsp_second_index = second_ff;
   assign rsp_avail_slot = aslot_ff;
   assign rsp_avail_count = acount_ff;
   assign rsp_used_ring_slot = uslot_ff;

`ifndef ASSERT_OFF
   a_pending_not_broken: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> !broken_ff)
      else $error("command pending on a broken queue");
`endif

endmodule

// ===== design/split_ring_descriptor_manager.sv =====
// driver side of a split descriptor ring with one command in flight
// req_ch takes one item per handshake: init, submit, completion or tick;
// the buffer fields are not used by the block, used_id only for completion
// rsp_ch returns exactly one item per request: status, chain indices,
// ring slots and the available counter after the item
// apb-style port: ring size at byte 0, timeout_ticks at byte 4, writes
// land on the access cycle, pready is tied high, reads return the value
// sequence: an init goes from acceptance straight to the execute step, any
// other item first does two next-pointer memory reads that overlap the 16-bit
// slot remainder at four bits a cycle, then the execute step; one item
// is in work at a time, so no new item is taken before the last one executes
// a new item is taken while the previous result still waits in the output
// register; if the receiver stalls, the next result waits in the execute
// step until the register frees, and no further item is accepted
// reset: ring size 64, timeout 200, counters and flags clear, free list
// chained 0..63 through valid bits, so no clearing pass is needed
module split_ring_descriptor_manager (
   input  logic                               clock,
   input  logic                               reset,
   srdm_req_if.sink                           req_ch,
   srdm_rsp_if.source                         rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [srdm_pkg::APB_ADDR_W-1:0]    paddr,
   input  logic [srdm_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [srdm_pkg::APB_DATA_W-1:0]    prdata,
   output logic                               pready
);

   // configuration registers
   logic [srdm_pkg::SIZE_W-1:0]   qsize_ff, qsize_in;
   logic [srdm_pkg::TICK_W-1:0]   timeout_ff, timeout_in;
   logic                          csr_write;

   // controller to datapath
   srdm_pkg::cmd_type             cmd;
   srdm_pkg::sts_type             sts;
   logic                          req_init;

   // write on the access phase; register picked by the word address bit
   assign csr_write = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      qsize_in = qsize_ff;
      timeout_in = timeout_ff;
      if (csr_write) begin
         unique case (paddr[2])
            srdm_pkg::REG_QSIZE: qsize_in = pwdata[srdm_pkg::SIZE_W-1:0];
            srdm_pkg::REG_TIMEOUT: timeout_in = pwdata[srdm_pkg::TICK_W-1:0];
            default: timeout_in = timeout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qsize_ff <= srdm_pkg::RESET_SIZE;
         timeout_ff <= srdm_pkg::RESET_TIMEOUT;
      end else begin
         qsize_ff <= qsize_in;
         timeout_ff <= timeout_in;
      end
   end

   // read back
   always_comb begin
      unique case (paddr[2])
         srdm_pkg::REG_QSIZE: prdata = srdm_pkg::APB_DATA_W'(qsize_ff);
         srdm_pkg::REG_TIMEOUT: prdata = srdm_pkg::APB_DATA_W'(timeout_ff);
         default: prdata = '0;
      endcase
   end

   // init needs no table reads, so it skips straight to execute
   assign req_init = (req_ch.kind == srdm_pkg::KIND_INIT);

   srdm_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_init  (req_init),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // descriptor tables, ring counters and the result register
   srdm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .qsize              (qsize_ff),
      .timeout_ticks      (timeout_ff),
      .req_kind           (req_ch.kind),
      .req_used_id        (req_ch.used_id),
      .rsp_status         (rsp_ch.status),
      .rsp_head_index     (rsp_ch.head_index),
      .rsp_second_index   (rsp_ch.second_index),
      .rsp_avail_slot     (rsp_ch.avail_slot),
      .rsp_avail_count    (rsp_ch.avail_count),
      .rsp_used_ring_slot (rsp_ch.used_ring_slot)
   );

endmodule
